// File: sv/rcsm_pkg.sv
// ============================================================================
// rcsm_pkg - shared types and constants for the RC show select controller
// Event codes, controller/datapath command and status structs, widths and
// the small helper functions used by the datapath.
// ============================================================================
package rcsm_pkg;

    // widths of the architectural fields
    localparam int MAX_SHOWS = 32;
    localparam int SHOW_W    = 5;
    localparam int COUNT_W   = 6;
    localparam int PULSE_W   = 15;
    localparam int CAL_W     = 12;
    localparam int HOLD_W    = 16;
    localparam int TIME_W    = 32;
    localparam int MASK_W    = MAX_SHOWS;
    localparam int CFG_IDX_W = 2;

    // shift-subtract divider
    localparam int DIV_NUM_W = 16;
    localparam int DIV_DEN_W = CAL_W;
    localparam int DIV_CNT_W = $clog2(DIV_NUM_W);

    localparam logic [HOLD_W-1:0]  HOLD_LONG_MS   = 16'd3000;
    localparam logic [HOLD_W-1:0]  TAP_MAX_MS     = 16'd1000;
    localparam logic [HOLD_W-1:0]  HOLD_SAT       = 16'hFFFF;
    localparam logic [PULSE_W-1:0] PULSE_MIN_US   = 15'd700;
    localparam logic [PULSE_W-1:0] PULSE_MAX_US   = 15'd2400;
    localparam logic [PULSE_W-1:0] SWITCH_UP_US   = 15'd1500;
    localparam logic [TIME_W-1:0]  AUTO_STEP_MS   = 32'd2000;
    localparam logic [TIME_W-1:0]  AUTO_PRIME_MS  = 32'd1995;
    localparam logic [CAL_W-1:0]   PULSE_LOW_RST  = 12'd1100;
    localparam logic [CAL_W-1:0]   PULSE_HIGH_RST = 12'd1900;

    // RC port lock codes
    localparam logic [1:0] RC_NONE  = 2'd0;
    localparam logic [1:0] RC_PORT1 = 2'd1;
    localparam logic [1:0] RC_PORT2 = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_NUM_SHOWS  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NUM_ACTIVE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SENSOR     = 2'd2;

    typedef enum logic [2:0] {
        EV_NONE        = 3'd0,
        EV_PROG_EXIT   = 3'd1,
        EV_PROG_ENTER  = 3'd2,
        EV_SHOW_TOGGLE = 3'd3,
        EV_PORT1       = 3'd4,
        EV_PORT2       = 3'd5,
        EV_NO_SIGNAL   = 3'd6,
        EV_NAV_TOGGLE  = 3'd7
    } t_event;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PORT,
        ST_DSTART,
        ST_DWAIT,
        ST_BTN,
        ST_OUT0,
        ST_OUT1
    } t_state;

    typedef struct packed {
        logic load;       // capture the polled item
        logic port;       // RC port evaluation
        logic div_start;  // launch the divider
        logic div_take;   // write divider result into the show index
        logic btn;        // button / hold evaluation
        logic out_sel;    // which event slot is on the output
    } t_cmd;

    typedef struct packed {
        logic prog;       // program mode active
        logic div_done;
        logic two_ev;     // this poll produced two events
    } t_sts;

    // a count of 0 acts as 1, anything above MAX_SHOWS acts as MAX_SHOWS
    function automatic logic [COUNT_W-1:0] eff_count(input logic [COUNT_W-1:0] n);
        logic [COUNT_W-1:0] r;
        if (n == '0) begin
            r = COUNT_W'(1);
        end else if (n > COUNT_W'(MAX_SHOWS)) begin
            r = COUNT_W'(MAX_SHOWS);
        end else begin
            r = n;
        end
        return r;
    endfunction

    function automatic logic [HOLD_W-1:0] hold_add(input logic [HOLD_W-1:0] h,
                                                   input logic [HOLD_W-1:0] d);
        logic [HOLD_W:0] s;
        s = {1'b0, h} + {1'b0, d};
        return s[HOLD_W] ? HOLD_SAT : s[HOLD_W-1:0];
    endfunction

endpackage

// File: sv/rcsm_div.sv
// ============================================================================
// rcsm_div - iterative unsigned divider
// Restoring shift-subtract divider, one quotient bit per clock. Produces
// quotient and remainder; o_done pulses together with the last step.
// ============================================================================
module rcsm_div
    import rcsm_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic [DIV_NUM_W-1:0] i_dividend,
    input  logic [DIV_DEN_W-1:0] i_divisor,
    output logic                 o_done,
    output logic [DIV_NUM_W-1:0] o_quotient,
    output logic [DIV_DEN_W-1:0] o_remainder
);

    logic                 r_busy;
    logic                 r_done;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [DIV_NUM_W-1:0] r_quo;
    logic [DIV_DEN_W-1:0] r_rem;
    logic [DIV_DEN_W-1:0] r_dvs;

    logic [DIV_DEN_W:0]   c_trial;
    logic [DIV_DEN_W:0]   c_diff;
    logic                 c_fit;

    assign c_trial = {r_rem, r_quo[DIV_NUM_W-1]};
    assign c_diff  = c_trial - {1'b0, r_dvs};
    assign c_fit   = (c_trial >= {1'b0, r_dvs});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && (r_cnt == '0)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
            r_cnt <= DIV_CNT_W'(DIV_NUM_W - 1);
        end else if (r_busy) begin
            r_quo <= {r_quo[DIV_NUM_W-2:0], c_fit};
            r_rem <= c_fit ? c_diff[DIV_DEN_W-1:0] : c_trial[DIV_DEN_W-1:0];
            r_cnt <= r_cnt - DIV_CNT_W'(1);
        end
    end

    assign o_done      = r_done;
    assign o_quotient  = r_quo;
    assign o_remainder = r_rem;

endmodule

// File: sv/rcsm_dp.sv
// ============================================================================
// rcsm_dp - datapath of the RC show select controller
// Holds the configuration and all controller state, evaluates RC ports and
// button holds under command of rcsm_ctrl, and maps port-1 pulses onto the
// show index through the shared divider.
// ============================================================================
module rcsm_dp
    import rcsm_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_cmd                 i_cmd,
    output t_sts                 o_sts,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [COUNT_W-1:0]   i_cfg_data,
    input  logic [TIME_W-1:0]    i_now_ms,
    input  logic                 i_cycle_button,
    input  logic                 i_enable_button,
    input  logic [PULSE_W-1:0]   i_ch1_pulse_us,
    input  logic [PULSE_W-1:0]   i_ch2_pulse_us,
    output logic [2:0]           o_event_res,
    output logic [SHOW_W-1:0]    o_show_index,
    output logic                 o_in_program_mode,
    output logic                 o_navlights_on,
    output logic [1:0]           o_rc_port_used,
    output logic                 o_show_enabled
);

    // captured item (payload, no reset)
    logic [TIME_W-1:0]  r_now;
    logic               r_cyc;
    logic               r_ena;
    logic [PULSE_W-1:0] r_p1;
    logic [PULSE_W-1:0] r_p2;
    logic [HOLD_W-1:0]  r_delta;

    // configuration and state
    logic [COUNT_W-1:0] r_num_shows,   n_num_shows;
    logic [COUNT_W-1:0] r_num_active,  n_num_active;
    logic               r_prog,        n_prog;
    logic [TIME_W-1:0]  r_last_time,   n_last_time;
    logic [HOLD_W-1:0]  r_cycle_hold,  n_cycle_hold;
    logic [HOLD_W-1:0]  r_enable_hold, n_enable_hold;
    logic [TIME_W-1:0]  r_auto_time,   n_auto_time;
    logic [1:0]         r_rc_port,     n_rc_port;
    logic [CAL_W-1:0]   r_pulse_low,   n_pulse_low;
    logic [CAL_W-1:0]   r_pulse_high,  n_pulse_high;
    logic [SHOW_W-1:0]  r_show,        n_show;
    logic [SHOW_W:0]    r_show_pre,    n_show_pre;
    logic               r_p1_path,     n_p1_path;
    logic [MASK_W-1:0]  r_mask,        n_mask;
    logic               r_nav,         n_nav;
    t_event             r_ev0,         n_ev0;
    t_event             r_ev1,         n_ev1;
    logic [1:0]         r_nev,         n_nev;

    logic [TIME_W-1:0]    c_delta_full;
    logic [HOLD_W-1:0]    c_delta_sat;
    logic [COUNT_W-1:0]   c_nas;
    logic [COUNT_W-1:0]   c_ns;
    logic                 c_p1_watch;
    logic                 c_p2_watch;
    logic                 c_p1_ok;
    logic                 c_p2_ok;
    logic [TIME_W-1:0]    c_auto_gap;
    logic [CAL_W-1:0]     c_p1_off;
    logic [CAL_W-1:0]     c_span;
    logic [DIV_NUM_W:0]   c_prod;
    logic [DIV_NUM_W-1:0] c_dividend;
    logic [DIV_DEN_W-1:0] c_divisor;
    logic                 c_div_done;
    logic [DIV_NUM_W-1:0] c_quo;
    logic [DIV_DEN_W-1:0] c_rem;
    logic [HOLD_W-1:0]    c_cyc_sum;
    logic [HOLD_W-1:0]    c_ena_sum;
    logic                 c_hold_long;
    logic                 c_cyc_tap;
    logic                 c_ena_tap;
    logic [SHOW_W:0]      c_show_inc;
    logic [SHOW_W-1:0]    c_prog_show;
    logic [SHOW_W-1:0]    c_btn_show;
    t_event               c_norm_ev;

    assign c_delta_full = i_now_ms - r_last_time;
    assign c_delta_sat  = (c_delta_full[TIME_W-1:HOLD_W] != '0) ? HOLD_SAT
                                                                 : c_delta_full[HOLD_W-1:0];

    assign c_nas = eff_count(r_num_active);
    assign c_ns  = eff_count(r_num_shows);

    assign c_p1_watch = (r_rc_port == RC_NONE) || (r_rc_port == RC_PORT1);
    assign c_p2_watch = (r_rc_port == RC_NONE) || (r_rc_port == RC_PORT2);
    assign c_p1_ok    = (r_p1 > PULSE_MIN_US) && (r_p1 < PULSE_MAX_US);
    assign c_p2_ok    = (r_p2 > PULSE_MIN_US) && (r_p2 < PULSE_MAX_US);
    assign c_auto_gap = r_now - r_auto_time;

    // calibration span never collapses: low <= 1100 and high >= 1900
    assign c_p1_off   = r_p1[CAL_W-1:0] - r_pulse_low;
    assign c_span     = r_pulse_high + CAL_W'(1) - r_pulse_low;
    assign c_prod     = (DIV_NUM_W+1)'(c_p1_off) * (DIV_NUM_W+1)'(c_nas);
    assign c_dividend = r_p1_path ? c_prod[DIV_NUM_W-1:0] : DIV_NUM_W'(r_show_pre);
    assign c_divisor  = r_p1_path ? c_span : DIV_DEN_W'(c_nas);

    rcsm_div u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_cmd.div_start),
        .i_dividend  (c_dividend),
        .i_divisor   (c_divisor),
        .o_done      (c_div_done),
        .o_quotient  (c_quo),
        .o_remainder (c_rem)
    );

    assign c_cyc_sum   = hold_add(r_cycle_hold, r_delta);
    assign c_ena_sum   = hold_add(r_enable_hold, r_delta);
    assign c_hold_long = (c_cyc_sum > HOLD_LONG_MS);
    assign c_cyc_tap   = (r_cycle_hold != '0) && (r_cycle_hold < TAP_MAX_MS);
    assign c_ena_tap   = (r_enable_hold != '0) && (r_enable_hold < TAP_MAX_MS);
    assign c_show_inc  = {1'b0, r_show} + (SHOW_W+1)'(1);
    assign c_prog_show = (c_show_inc >= c_ns) ? '0 : c_show_inc[SHOW_W-1:0];
    assign c_btn_show  = (!r_cyc && c_cyc_tap) ? c_prog_show : r_show;
    assign c_norm_ev   = r_cyc ? EV_PROG_ENTER : EV_NAV_TOGGLE;

    always_comb begin
        n_num_shows   = r_num_shows;
        n_num_active  = r_num_active;
        n_prog        = r_prog;
        n_last_time   = r_last_time;
        n_cycle_hold  = r_cycle_hold;
        n_enable_hold = r_enable_hold;
        n_auto_time   = r_auto_time;
        n_rc_port     = r_rc_port;
        n_pulse_low   = r_pulse_low;
        n_pulse_high  = r_pulse_high;
        n_show        = r_show;
        n_show_pre    = r_show_pre;
        n_p1_path     = r_p1_path;
        n_mask        = r_mask;
        n_nav         = r_nav;
        n_ev0         = r_ev0;
        n_ev1         = r_ev1;
        n_nev         = r_nev;

        if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_NUM_SHOWS:  n_num_shows  = i_cfg_data;
                CFG_NUM_ACTIVE: n_num_active = i_cfg_data;
                CFG_SENSOR:     ; // indicator flash only, no result field
                default:        ;
            endcase
        end

        if (i_cmd.load) begin
            n_ev0 = EV_NONE;
            n_ev1 = EV_NONE;
            n_nev = 2'd0;
        end

        if (i_cmd.port) begin
            n_p1_path  = 1'b0;
            n_show_pre = {1'b0, r_show};
            if (c_p1_watch && c_p1_ok) begin
                n_p1_path = 1'b1;
                if (r_p1 > PULSE_W'(r_pulse_high)) begin
                    n_pulse_high = r_p1[CAL_W-1:0];
                end
                if (r_p1 < PULSE_W'(r_pulse_low)) begin
                    n_pulse_low = r_p1[CAL_W-1:0];
                end
                if (r_rc_port == RC_NONE) begin
                    n_rc_port = RC_PORT1;
                    n_ev0     = EV_PORT1;
                    n_nev     = 2'd1;
                end
            end else if (c_p2_watch && c_p2_ok) begin
                if (r_rc_port == RC_NONE) begin
                    n_rc_port = RC_PORT2;
                    n_ev0     = EV_PORT2;
                    n_nev     = 2'd1;
                end
                // switch up: step the show every 2 s; switch down primes the timer
                if (r_p2 > SWITCH_UP_US) begin
                    if (c_auto_gap > AUTO_STEP_MS) begin
                        n_show_pre  = c_show_inc;
                        n_auto_time = r_now;
                    end
                end else begin
                    n_auto_time = r_now - AUTO_PRIME_MS;
                end
            end else if (r_rc_port == RC_NONE) begin
                n_ev0 = EV_NO_SIGNAL;
                n_nev = 2'd1;
            end
        end

        // port 1: quotient is already below the active count; else take the remainder
        if (i_cmd.div_take) begin
            n_show = r_p1_path ? c_quo[SHOW_W-1:0] : c_rem[SHOW_W-1:0];
        end

        if (i_cmd.btn) begin
            n_last_time = r_now;
            if (r_prog) begin
                if (r_cyc) begin
                    if (c_hold_long) begin
                        n_prog       = 1'b0;
                        n_cycle_hold = '0;
                        n_ev0        = EV_PROG_EXIT;
                        n_nev        = 2'd1;
                    end else begin
                        n_cycle_hold = c_cyc_sum;
                    end
                end else begin
                    n_show       = c_btn_show;
                    n_cycle_hold = '0;
                end
                if (r_ena) begin
                    n_enable_hold = c_ena_sum;
                end else begin
                    if (c_ena_tap) begin
                        n_mask = r_mask ^ (MASK_W'(1) << c_btn_show);
                        if (r_cyc && c_hold_long) begin
                            n_ev1 = EV_SHOW_TOGGLE;
                            n_nev = 2'd2;
                        end else begin
                            n_ev0 = EV_SHOW_TOGGLE;
                            n_nev = 2'd1;
                        end
                    end
                    n_enable_hold = '0;
                end
            end else begin
                // normal mode: both buttons share the cycle hold counter
                if (r_cyc || r_ena) begin
                    if (c_hold_long) begin
                        n_cycle_hold = '0;
                        if (r_cyc) begin
                            n_prog = 1'b1;
                            n_show = '0;
                        end else begin
                            n_nav = ~r_nav;
                        end
                        if (r_nev == 2'd0) begin
                            n_ev0 = c_norm_ev;
                            n_nev = 2'd1;
                        end else begin
                            n_ev1 = c_norm_ev;
                            n_nev = 2'd2;
                        end
                    end else begin
                        n_cycle_hold = c_cyc_sum;
                    end
                end else begin
                    n_cycle_hold = '0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_shows   <= COUNT_W'(MAX_SHOWS);
            r_num_active  <= COUNT_W'(MAX_SHOWS);
            r_prog        <= 1'b0;
            r_last_time   <= '0;
            r_cycle_hold  <= '0;
            r_enable_hold <= '0;
            r_auto_time   <= '0;
            r_rc_port     <= RC_NONE;
            r_pulse_low   <= PULSE_LOW_RST;
            r_pulse_high  <= PULSE_HIGH_RST;
            r_show        <= '0;
            r_show_pre    <= '0;
            r_p1_path     <= 1'b0;
            r_mask        <= '1;
            r_nav         <= 1'b1;
            r_ev0         <= EV_NONE;
            r_ev1         <= EV_NONE;
            r_nev         <= 2'd0;
        end else begin
            r_num_shows   <= n_num_shows;
            r_num_active  <= n_num_active;
            r_prog        <= n_prog;
            r_last_time   <= n_last_time;
            r_cycle_hold  <= n_cycle_hold;
            r_enable_hold <= n_enable_hold;
            r_auto_time   <= n_auto_time;
            r_rc_port     <= n_rc_port;
            r_pulse_low   <= n_pulse_low;
            r_pulse_high  <= n_pulse_high;
            r_show        <= n_show;
            r_show_pre    <= n_show_pre;
            r_p1_path     <= n_p1_path;
            r_mask        <= n_mask;
            r_nav         <= n_nav;
            r_ev0         <= n_ev0;
            r_ev1         <= n_ev1;
            r_nev         <= n_nev;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_now   <= i_now_ms;
            r_cyc   <= i_cycle_button;
            r_ena   <= i_enable_button;
            r_p1    <= i_ch1_pulse_us;
            r_p2    <= i_ch2_pulse_us;
            r_delta <= c_delta_sat;
        end
    end

    assign o_sts.prog     = r_prog;
    assign o_sts.div_done = c_div_done;
    assign o_sts.two_ev   = (r_nev == 2'd2);

    assign o_event_res       = i_cmd.out_sel ? r_ev1 : r_ev0;
    assign o_show_index      = r_show;
    assign o_in_program_mode = r_prog;
    assign o_navlights_on    = r_nav;
    assign o_rc_port_used    = r_rc_port;
    assign o_show_enabled    = r_mask[r_show];

`ifndef NO_ASSERTIONS
    a_port_lock_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_rc_port != RC_NONE) |=> (r_rc_port == $past(r_rc_port)))
        else $error("locked RC port changed");

    a_cal_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pulse_low < r_pulse_high))
        else $error("calibration span collapsed");

    a_p1_quo_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.div_take && r_p1_path) |-> (c_quo < DIV_NUM_W'(c_nas)))
        else $error("port 1 show index above active count");
`endif

endmodule

// File: sv/rcsm_ctrl.sv
// ============================================================================
// rcsm_ctrl - sequencer of the RC show select controller
// Steps one poll through port evaluation and the divider (normal mode only),
// button evaluation and the one or two result items, driving rcsm_dp.
// ============================================================================
module rcsm_ctrl
    import rcsm_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    output logic o_out_valid,
    input  logic i_out_ready,
    output logic o_out_last,
    output t_cmd o_cmd,
    input  t_sts i_sts
);

    t_state r_state, n_state;

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = i_sts.prog ? ST_BTN : ST_PORT;
                end
            end
            ST_PORT:   n_state = ST_DSTART;
            ST_DSTART: n_state = ST_DWAIT;
            ST_DWAIT: begin
                if (i_sts.div_done) begin
                    n_state = ST_BTN;
                end
            end
            ST_BTN:    n_state = ST_OUT0;
            ST_OUT0: begin
                if (i_out_ready) begin
                    n_state = i_sts.two_ev ? ST_OUT1 : ST_IDLE;
                end
            end
            ST_OUT1: begin
                if (i_out_ready) begin
                    n_state = ST_IDLE;
                end
            end
            default:   n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        o_out_last  = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            ST_PORT:   o_cmd.port      = 1'b1;
            ST_DSTART: o_cmd.div_start = 1'b1;
            ST_DWAIT:  o_cmd.div_take  = i_sts.div_done;
            ST_BTN:    o_cmd.btn       = 1'b1;
            ST_OUT0: begin
                o_out_valid = 1'b1;
                o_out_last  = !i_sts.two_ev;
            end
            ST_OUT1: begin
                o_out_valid   = 1'b1;
                o_out_last    = 1'b1;
                o_cmd.out_sel = 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

`ifndef NO_ASSERTIONS
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("new item taken while a poll is in flight");

    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !o_in_ready)
        else $error("input open while a result is pending");

    a_last_frees: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_ready && o_out_last) |=> o_in_ready)
        else $error("not idle after final result");

    a_second_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_ready && !o_out_last) |=> (o_out_valid && o_out_last))
        else $error("second result missing");
`endif

endmodule

// File: sv/rc_show_select_mode_control.sv
// ============================================================================
// rc_show_select_mode_control - RC and push-button show selection
// Top level: sequencer plus datapath for one poll at a time.
// ============================================================================
// Each accepted poll gives one or two result items, the last flagged by
// o_last, all carrying the state after the poll. In normal mode a poll
// goes through port evaluation and the 16-step shift-subtract divider,
// which maps a port-1 pulse onto a show index (or reduces the show index
// modulo the active count); in program mode it goes straight to button
// evaluation. The block is ready again in the cycle after the last result
// is taken. The user must write configuration through i_cfg_we/i_cfg_idx/
// i_cfg_data only while no poll is in flight; the block does not enforce it.
module rc_show_select_mode_control
    import rcsm_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [COUNT_W-1:0]   i_cfg_data,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic [TIME_W-1:0]    i_now_ms,
    input  logic                 i_cycle_button,
    input  logic                 i_enable_button,
    input  logic [PULSE_W-1:0]   i_ch1_pulse_us,
    input  logic [PULSE_W-1:0]   i_ch2_pulse_us,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic [2:0]           o_event_res,
    output logic [SHOW_W-1:0]    o_show_index,
    output logic                 o_in_program_mode,
    output logic                 o_navlights_on,
    output logic [1:0]           o_rc_port_used,
    output logic                 o_show_enabled,
    output logic                 o_last
);

    t_cmd c_cmd;
    t_sts c_sts;

    rcsm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_last  (o_last),
        .o_cmd       (c_cmd),
        .i_sts       (c_sts)
    );

    rcsm_dp u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (c_cmd),
        .o_sts             (c_sts),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_idx         (i_cfg_idx),
        .i_cfg_data        (i_cfg_data),
        .i_now_ms          (i_now_ms),
        .i_cycle_button    (i_cycle_button),
        .i_enable_button   (i_enable_button),
        .i_ch1_pulse_us    (i_ch1_pulse_us),
        .i_ch2_pulse_us    (i_ch2_pulse_us),
        .o_event_res       (o_event_res),
        .o_show_index      (o_show_index),
        .o_in_program_mode (o_in_program_mode),
        .o_navlights_on    (o_navlights_on),
        .o_rc_port_used    (o_rc_port_used),
        .o_show_enabled    (o_show_enabled)
    );

endmodule

// File: bench/rc_show_select_mode_control_tb.sv
// ============================================================================
// rc_show_select_mode_control_tb - self-checking bench for the show selector
// Drives polls over the valid/ready input channel, tracks the expected
// selector state in a behavioral model and checks every result item in
// order. Directed polls cover search, program mode, navlights and the port
// lock; random button episodes and RC traffic then run under several
// register settings, with random idle cycles on both channels.
// ============================================================================
module rc_show_select_mode_control_tb;
    import rcsm_pkg::*;

    localparam int unsigned LONG_PRESS_MS  = 3000;
    localparam int unsigned TAP_LIMIT_MS   = 1000;
    localparam int unsigned RC_MIN_US      = 700;
    localparam int unsigned RC_MAX_US      = 2400;
    localparam int unsigned SWITCH_MID_US  = 1500;
    localparam int unsigned AUTO_PERIOD_MS = 2000;
    localparam int unsigned AUTO_LEAD_MS   = 1995;
    localparam int          CYCLE_LIMIT    = 400000;

    typedef struct packed {
        logic [TIME_W-1:0]  now;
        logic               cyc;
        logic               ena;
        logic [PULSE_W-1:0] ch1;
        logic [PULSE_W-1:0] ch2;
    } t_poll;

    typedef struct packed {
        t_event            ev;
        logic [SHOW_W-1:0] show;
        logic              prog;
        logic              nav;
        logic [1:0]        port;
        logic              en;
        logic              fin;
    } t_sel_result;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [COUNT_W-1:0]   i_cfg_data;
    logic                 i_in_valid;
    logic                 o_in_ready;
    logic [TIME_W-1:0]    i_now_ms;
    logic                 i_cycle_button;
    logic                 i_enable_button;
    logic [PULSE_W-1:0]   i_ch1_pulse_us;
    logic [PULSE_W-1:0]   i_ch2_pulse_us;
    logic                 o_out_valid;
    logic                 i_out_ready;
    logic [2:0]           o_event_res;
    logic [SHOW_W-1:0]    o_show_index;
    logic                 o_in_program_mode;
    logic                 o_navlights_on;
    logic [1:0]           o_rc_port_used;
    logic                 o_show_enabled;
    logic                 o_last;

    // selector state as the block should hold it
    logic                 prog_on;
    logic [TIME_W-1:0]    prev_ms;
    logic [HOLD_W-1:0]    cyc_hold;
    logic [HOLD_W-1:0]    ena_hold;
    logic [TIME_W-1:0]    auto_mark;
    logic [1:0]           port_lock;
    logic [CAL_W-1:0]     cal_low;
    logic [CAL_W-1:0]     cal_high;
    logic [SHOW_W-1:0]    show_sel;
    logic [MASK_W-1:0]    show_mask;
    logic                 nav_on;
    logic [COUNT_W-1:0]   cfg_shows;
    logic [COUNT_W-1:0]   cfg_active;
    logic                 cfg_sensor;

    t_sel_result results_due[$];
    t_sel_result want_r;

    logic [TIME_W-1:0] wall_ms;
    bit  steady;
    int  fail_count;
    int  polls_sent;
    int  results_checked;
    int  settings_run;
    int  prog_entries;
    int  nav_toggles;
    int  cycle_count;

    rc_show_select_mode_control DUT (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_idx         (i_cfg_idx),
        .i_cfg_data        (i_cfg_data),
        .i_in_valid        (i_in_valid),
        .o_in_ready        (o_in_ready),
        .i_now_ms          (i_now_ms),
        .i_cycle_button    (i_cycle_button),
        .i_enable_button   (i_enable_button),
        .i_ch1_pulse_us    (i_ch1_pulse_us),
        .i_ch2_pulse_us    (i_ch2_pulse_us),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_event_res       (o_event_res),
        .o_show_index      (o_show_index),
        .o_in_program_mode (o_in_program_mode),
        .o_navlights_on    (o_navlights_on),
        .o_rc_port_used    (o_rc_port_used),
        .o_show_enabled    (o_show_enabled),
        .o_last            (o_last)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // behavioral model of the selector
    // ------------------------------------------------------------------
    function automatic logic [31:0] shows_in_use(input logic [COUNT_W-1:0] n);
        if (n == '0) begin
            return 32'd1;
        end else if (n > MAX_SHOWS) begin
            return MAX_SHOWS;
        end
        return 32'(n);
    endfunction

    function automatic logic [HOLD_W-1:0] hold_sum(input logic [HOLD_W-1:0] h,
                                                   input logic [TIME_W-1:0] d);
        logic [32:0] s;
        s = 33'(h) + 33'(d);
        return (s > 33'd65535) ? 16'hFFFF : s[HOLD_W-1:0];
    endfunction

    function automatic bit pulse_ok(input logic [PULSE_W-1:0] p);
        return (p > RC_MIN_US) && (p < RC_MAX_US);
    endfunction

    task automatic step_selector(input t_poll p);
        logic [TIME_W-1:0] delta;
        logic [31:0]       active_n;
        logic [31:0]       show_w;
        int                nxt;
        t_event            evs[2];
        int                nev;
        int                k;
        t_sel_result       r;
        delta = p.now - prev_ms;
        nev = 0;
        if (prog_on) begin
            if (p.cyc) begin
                cyc_hold = hold_sum(cyc_hold, delta);
                if (cyc_hold > LONG_PRESS_MS) begin
                    prog_on = 1'b0;
                    cyc_hold = '0;
                    evs[nev] = EV_PROG_EXIT;
                    nev++;
                end
            end else begin
                // a short press on the cycle button steps to the next show
                if (cyc_hold > 0 && cyc_hold < TAP_LIMIT_MS) begin
                    nxt = int'(show_sel) + 1;
                    show_sel = (nxt >= shows_in_use(cfg_shows)) ? '0 : SHOW_W'(nxt);
                end
                cyc_hold = '0;
            end
            if (p.ena) begin
                ena_hold = hold_sum(ena_hold, delta);
            end else begin
                if (ena_hold > 0 && ena_hold < TAP_LIMIT_MS) begin
                    show_mask[show_sel] = ~show_mask[show_sel];
                    evs[nev] = EV_SHOW_TOGGLE;
                    nev++;
                end
                ena_hold = '0;
            end
        end else begin
            active_n = shows_in_use(cfg_active);
            show_w = 32'(show_sel);
            if (port_lock == RC_NONE || port_lock == RC_PORT1) begin
                if (pulse_ok(p.ch1)) begin
                    // calibration span only ever widens
                    if (p.ch1 > cal_high) cal_high = p.ch1[CAL_W-1:0];
                    if (p.ch1 < cal_low) cal_low = p.ch1[CAL_W-1:0];
                    if (port_lock == RC_NONE) begin
                        port_lock = RC_PORT1;
                        evs[nev] = EV_PORT1;
                        nev++;
                    end
                    show_w = ((32'(p.ch1) - 32'(cal_low)) * active_n)
                             / (32'(cal_high) + 32'd1 - 32'(cal_low));
                end
            end
            if (port_lock == RC_NONE || port_lock == RC_PORT2) begin
                if (pulse_ok(p.ch2)) begin
                    if (port_lock == RC_NONE) begin
                        port_lock = RC_PORT2;
                        evs[nev] = EV_PORT2;
                        nev++;
                    end
                    if (p.ch2 > SWITCH_MID_US) begin
                        if (p.now - auto_mark > AUTO_PERIOD_MS) begin
                            show_w = show_w + 32'd1;
                            auto_mark = p.now;
                        end
                    end else begin
                        // switch down: arm so the next up position steps at once
                        auto_mark = p.now - AUTO_LEAD_MS;
                    end
                end
            end
            if (port_lock == RC_NONE) begin
                evs[nev] = EV_NO_SIGNAL;
                nev++;
            end
            show_sel = SHOW_W'(show_w % active_n);
            // in normal mode both buttons share the cycle hold counter
            if (p.cyc) begin
                cyc_hold = hold_sum(cyc_hold, delta);
                if (cyc_hold > LONG_PRESS_MS) begin
                    prog_on = 1'b1;
                    cyc_hold = '0;
                    show_sel = '0;
                    evs[nev] = EV_PROG_ENTER;
                    nev++;
                    prog_entries++;
                end
            end else if (p.ena) begin
                cyc_hold = hold_sum(cyc_hold, delta);
                if (cyc_hold > LONG_PRESS_MS) begin
                    nav_on = ~nav_on;
                    cyc_hold = '0;
                    evs[nev] = EV_NAV_TOGGLE;
                    nev++;
                    nav_toggles++;
                end
            end else begin
                cyc_hold = '0;
            end
        end
        prev_ms = p.now;

        if (nev == 0) begin
            evs[0] = EV_NONE;
            nev = 1;
        end
        for (k = 0; k < nev; k++) begin
            r.ev   = evs[k];
            r.show = show_sel;
            r.prog = prog_on;
            r.nav  = nav_on;
            r.port = port_lock;
            r.en   = show_mask[show_sel];
            r.fin  = (k == nev - 1);
            results_due.push_back(r);
        end
    endtask

    // ------------------------------------------------------------------
    // channel drivers
    // ------------------------------------------------------------------
    task automatic send_poll(input logic [TIME_W-1:0] now, input logic cyc,
                             input logic ena, input logic [PULSE_W-1:0] ch1,
                             input logic [PULSE_W-1:0] ch2);
        int    gap;
        t_poll p;
        if (!steady && $urandom_range(99) < 18) begin
            gap = $urandom_range(1, 12);
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        p.now = now;
        p.cyc = cyc;
        p.ena = ena;
        p.ch1 = ch1;
        p.ch2 = ch2;
        i_in_valid      <= 1'b1;
        i_now_ms        <= now;
        i_cycle_button  <= cyc;
        i_enable_button <= ena;
        i_ch1_pulse_us  <= ch1;
        i_ch2_pulse_us  <= ch2;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        step_selector(p);
        wall_ms = now;
        polls_sent++;
    endtask

    // wait until every expected result is in and the block takes items again
    task automatic drain();
        i_in_valid <= 1'b0;
        while (results_due.size() != 0) @(posedge i_clk);
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    task automatic load_settings(input logic [COUNT_W-1:0] shows,
                                 input logic [COUNT_W-1:0] active, input bit sensor);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_NUM_SHOWS;
        i_cfg_data <= shows;
        @(posedge i_clk);
        i_cfg_idx  <= CFG_NUM_ACTIVE;
        i_cfg_data <= active;
        @(posedge i_clk);
        i_cfg_idx  <= CFG_SENSOR;
        i_cfg_data <= COUNT_W'(sensor);
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        cfg_shows  = shows;
        cfg_active = active;
        cfg_sensor = sensor;
        settings_run++;
    endtask

    always @(posedge i_clk) begin
        i_out_ready <= steady || ($urandom_range(99) >= 18);
    end

    // ------------------------------------------------------------------
    // result checking
    // ------------------------------------------------------------------
    function automatic void check_field(input string label, input logic [31:0] want,
                                        input logic [31:0] got);
        if (want !== got) begin
            $error("%s mismatch: expected %0d, got %0d", label, want, got);
            fail_count++;
        end
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (results_due.size() == 0) begin
                $error("result item with nothing expected: event %0d show %0d",
                       o_event_res, o_show_index);
                fail_count++;
            end else begin
                want_r = results_due.pop_front();
                check_field("event_res", 32'(want_r.ev), 32'(o_event_res));
                check_field("show_index", 32'(want_r.show), 32'(o_show_index));
                check_field("in_program_mode", 32'(want_r.prog), 32'(o_in_program_mode));
                check_field("navlights_on", 32'(want_r.nav), 32'(o_navlights_on));
                check_field("rc_port_used", 32'(want_r.port), 32'(o_rc_port_used));
                check_field("show_enabled", 32'(want_r.en), 32'(o_show_enabled));
                check_field("last", 32'(want_r.fin), 32'(o_last));
                results_checked++;
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $error("timeout after %0d cycles, %0d results outstanding",
                   cycle_count, results_due.size());
            $display("Verification failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------
    // no RC signal yet: invalid and boundary pulses keep the search going
    task automatic test_searching();
        send_poll(32'd100, 1'b0, 1'b0, 15'd0, 15'd0);
        send_poll(32'd150, 1'b0, 1'b0, 15'd700, 15'd2400);
        send_poll(32'd200, 1'b0, 1'b0, 15'd25000, 15'd25000);
        send_poll(32'd250, 1'b0, 1'b0, 15'h2AAA, 15'h5555);
    endtask

    task automatic test_program_mode();
        send_poll(32'd300, 1'b1, 1'b0, 15'd0, 15'd0);
        send_poll(32'd3400, 1'b1, 1'b0, 15'd0, 15'd0);     // long hold: enter
        send_poll(32'd3500, 1'b1, 1'b0, 15'd1500, 15'd0);
        send_poll(32'd3600, 1'b0, 1'b0, 15'd0, 15'd1500);  // tap: next show
        send_poll(32'd3700, 1'b0, 1'b1, 15'd0, 15'd0);
        send_poll(32'd3800, 1'b0, 1'b0, 15'd0, 15'd0);     // enable tap
        send_poll(32'd3900, 1'b1, 1'b1, 15'd0, 15'd0);
        send_poll(32'd7100, 1'b1, 1'b0, 15'd0, 15'd0);     // exit and toggle together
    endtask

    // enable hold saturates the counter and flips the navlights
    task automatic test_navlights();
        send_poll(32'd7150, 1'b0, 1'b1, 15'd0, 15'd0);
        send_poll(32'h0002_0000, 1'b0, 1'b1, 15'd0, 15'd0);
    endtask

    task automatic test_port_lock();
        bit lock_two;
        lock_two = 1'($urandom_range(1));
        // lock together with a saturated cycle hold, then leave across the wrap
        if (lock_two) begin
            send_poll(32'hFFFF_FF00, 1'b1, 1'b0, 15'd0, 15'd2399);
        end else begin
            send_poll(32'hFFFF_FF00, 1'b1, 1'b0, 15'd701, 15'd1600);
        end
        send_poll(32'h0000_0C00, 1'b1, 1'b0, 15'd0, 15'd0);
        send_poll(32'h0000_0D00, 1'b0, 1'b0, 15'd2399, 15'd1000);
        send_poll(32'h0000_0E00, 1'b0, 1'b0, 15'd1500, 15'd701);
        send_poll(32'h0000_1000, 1'b0, 1'b0, 15'd0, 15'd2399);
        send_poll(32'h0000_17D1, 1'b0, 1'b0, 15'd1200, 15'd1600);
        send_poll(32'h0000_1FA2, 1'b0, 1'b0, 15'd1000, 15'd1600);
    endtask

    function automatic logic [PULSE_W-1:0] boundary_pulse();
        case ($urandom_range(6))
            0: return 15'd0;
            1: return 15'd700;
            2: return 15'd701;
            3: return 15'd1500;
            4: return 15'd1501;
            5: return 15'd2399;
            default: return 15'd2400;
        endcase
    endfunction

    // button episodes (press, then release) with RC traffic and some noise
    task automatic test_random_traffic(input int n_polls, input logic [COUNT_W-1:0] shows,
                                       input logic [COUNT_W-1:0] active, input bit sensor,
                                       input bit no_idle);
        int                 i;
        int                 left;
        int                 step_lo;
        int                 step_hi;
        int                 pick;
        bit                 cyc;
        bit                 ena;
        bit                 was_pressed;
        bit                 sw_up;
        logic               c;
        logic               e;
        logic [TIME_W-1:0]  now_v;
        logic [PULSE_W-1:0] p1;
        logic [PULSE_W-1:0] p2;
        drain();
        load_settings(shows, active, sensor);
        steady = no_idle;
        left = 0;
        was_pressed = 1'b0;
        sw_up = 1'($urandom_range(1));
        for (i = 0; i < n_polls; i++) begin
            if (left == 0) begin
                cyc = 1'b0;
                ena = 1'b0;
                pick = $urandom_range(99);
                if (!was_pressed && pick < 85) begin
                    pick = $urandom_range(99);
                    if (pick < 45) cyc = 1'b1;
                    else if (pick < 85) ena = 1'b1;
                    else begin
                        cyc = 1'b1;
                        ena = 1'b1;
                    end
                end
                was_pressed = cyc || ena;
                case (was_pressed ? $urandom_range(2) : 0)
                    0: begin
                        left = $urandom_range(1, 4);
                        step_lo = 20;
                        step_hi = 200;
                    end
                    1: begin
                        left = $urandom_range(2, 8);
                        step_lo = 150;
                        step_hi = 450;
                    end
                    default: begin
                        left = $urandom_range(8, 16);
                        step_lo = 250;
                        step_hi = 500;
                    end
                endcase
            end
            if ($urandom_range(99) < 8) begin
                if ($urandom_range(1)) now_v = $urandom();
                else now_v = wall_ms + $urandom_range(3000, 80000);
                c = 1'($urandom_range(1));
                e = 1'($urandom_range(1));
            end else begin
                now_v = wall_ms + $urandom_range(step_lo, step_hi);
                c = cyc;
                e = ena;
                left--;
            end

            pick = $urandom_range(99);
            if (pick < 70) p1 = 15'($urandom_range(701, 2399));
            else if (pick < 80) p1 = boundary_pulse();
            else if (pick < 90) p1 = '0;
            else p1 = 15'($urandom_range(0, 25000));

            if ($urandom_range(99) < 8) sw_up = !sw_up;
            pick = $urandom_range(99);
            if (pick < 75) begin
                p2 = sw_up ? 15'($urandom_range(1501, 2399)) : 15'($urandom_range(701, 1500));
            end else if (pick < 85) p2 = boundary_pulse();
            else if (pick < 92) p2 = '0;
            else p2 = 15'($urandom_range(0, 25000));

            send_poll(now_v, c, e, p1, p2);
        end
        steady = 1'b0;
    endtask

    initial begin
        i_rst_n         <= 1'b0;
        i_cfg_we        <= 1'b0;
        i_cfg_idx       <= CFG_NUM_SHOWS;
        i_cfg_data      <= '0;
        i_in_valid      <= 1'b0;
        i_now_ms        <= '0;
        i_cycle_button  <= 1'b0;
        i_enable_button <= 1'b0;
        i_ch1_pulse_us  <= '0;
        i_ch2_pulse_us  <= '0;
        i_out_ready     <= 1'b0;
        prog_on    = 1'b0;
        prev_ms    = '0;
        cyc_hold   = '0;
        ena_hold   = '0;
        auto_mark  = '0;
        port_lock  = RC_NONE;
        cal_low    = 12'd1100;
        cal_high   = 12'd1900;
        show_sel   = '0;
        show_mask  = '1;
        nav_on     = 1'b1;
        cfg_shows  = 6'd32;
        cfg_active = 6'd32;
        cfg_sensor = 1'b0;
        wall_ms = '0;
        steady = 1'b0;
        fail_count = 0;
        polls_sent = 0;
        results_checked = 0;
        settings_run = 1;
        prog_entries = 0;
        nav_toggles = 0;
        cycle_count = 0;

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_searching();
        test_program_mode();
        test_navlights();
        test_port_lock();
        test_random_traffic(190, 6'd32, 6'd32, 1'b0, 1'b0);
        test_random_traffic(190, 6'd1, 6'd1, 1'b1, 1'b0);
        test_random_traffic(190, 6'd0, 6'd0, 1'b0, 1'b0);
        test_random_traffic(190, 6'd63, 6'd63, 1'b1, 1'b0);
        test_random_traffic(190, 6'($urandom_range(1, 32)), 6'($urandom_range(1, 32)),
                            1'($urandom_range(1)), 1'b1);
        test_random_traffic(190, 6'($urandom_range(2, 8)), 6'($urandom_range(1, 32)),
                            1'b0, 1'b0);
        drain();
        repeat (40) @(posedge i_clk);

        if (results_due.size() != 0) begin
            $error("%0d expected result items never arrived", results_due.size());
            fail_count++;
        end
        $display("Ran %0d polls under %0d register settings, %0d result items checked",
                 polls_sent, settings_run, results_checked);
        $display("Program mode entered %0d times, navlights flipped %0d times, port %0d held",
                 prog_entries, nav_toggles, port_lock);
        if (fail_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

// File: filelist.f
sv/rcsm_pkg.sv
sv/rcsm_div.sv
sv/rcsm_dp.sv
sv/rcsm_ctrl.sv
sv/rc_show_select_mode_control.sv
bench/rc_show_select_mode_control_tb.sv
